// ===== src/radix64_comment_payload_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix-64 comment payload decoder
// Short forms for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RADIX64_COMMENT_PAYLOAD_DECODER_TOP_ASSERT_SVH
`define RADIX64_COMMENT_PAYLOAD_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define R64CPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("decoder check failed");

// Next-cycle implication, checked outside reset.
`define R64CPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("decoder check failed");

`endif

// ===== src/r64cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// r64cpd_pkg
// Types, character codes and the digit table of the comment payload decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package r64cpd_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_BLANKS  = 2'd1,
      MODE_COMMENT = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      TAG_WANT_F     = 3'd0,
      TAG_WANT_W     = 3'd1,
      TAG_WANT_COLON = 3'd2,
      TAG_DECODING   = 3'd3,
      TAG_STOPPED    = 3'd4
   } tag_type;

   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_END      = 2'd1,
      STATUS_ERROR    = 2'd2
   } status_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_TAG0  = 8'h46;
   localparam logic [7:0] CHAR_TAG1  = 8'h57;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DIG0  = 8'h30;
   localparam logic [7:0] CHAR_DIG9  = 8'h39;
   localparam logic [7:0] CHAR_UPA   = 8'h41;
   localparam logic [7:0] CHAR_UPZ   = 8'h5A;
   localparam logic [7:0] CHAR_LOA   = 8'h61;
   localparam logic [7:0] CHAR_LOZ   = 8'h7A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [5:0] UPPER_BASE = 6'd10;
   localparam logic [5:0] LOWER_BASE = 6'd36;
   localparam logic [5:0] DOT_VALUE  = 6'd62;
   localparam logic [5:0] SLASH_VALUE = 6'd63;

   typedef struct packed {
      mode_type   mode;
      tag_type    tag;
      logic [1:0] phase;
      logic [5:0] d0;
      logic [5:0] d1;
      logic [5:0] d2;
   } dec_state_type;

   typedef struct packed {
      logic [7:0] byte_hi;
      logic [7:0] byte_mid;
      logic [7:0] byte_lo;
      logic       bytes_ready;
      status_type status;
   } dec_result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   // Returns {valid, value}; valid is low for characters outside the alphabet.
   function automatic logic [6:0] digit_value(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'd0;
      if ((c >= CHAR_DIG0) && (c <= CHAR_DIG9)) begin
         diff = c - CHAR_DIG0;
         return {1'b1, diff[5:0]};
      end else if ((c >= CHAR_UPA) && (c <= CHAR_UPZ)) begin
         diff = c - CHAR_UPA;
         return {1'b1, diff[5:0] + UPPER_BASE};
      end else if ((c >= CHAR_LOA) && (c <= CHAR_LOZ)) begin
         diff = c - CHAR_LOA;
         return {1'b1, diff[5:0] + LOWER_BASE};
      end else if (c == CHAR_DOT) begin
         return {1'b1, DOT_VALUE};
      end else if (c == CHAR_SLASH) begin
         return {1'b1, SLASH_VALUE};
      end
      return 7'd0;
   endfunction

endpackage

`default_nettype wire

// ===== src/r64cpd_step.sv =====
// ----------------------------------------------------------------------------
// r64cpd_step
// Next-state and result logic for one character of the separator region.
// ----------------------------------------------------------------------------
`default_nettype none

module r64cpd_step
   import r64cpd_pkg::*;
(
   input  wire dec_state_type  cur_state,
   input  wire logic [7:0]     char_code,
   input  wire logic           first_of_region,
   input  wire logic           end_of_input,
   output dec_state_type       next_state,
   output dec_result_type      result
);

   logic       start;
   logic       blank;
   logic [6:0] dig;
   mode_type   mode_eff;

   always_comb begin
      start = first_of_region ||
              ((cur_state.mode != MODE_BLANKS) && (cur_state.mode != MODE_COMMENT));
      blank = is_blank(char_code);
      dig   = digit_value(char_code);

      next_state = cur_state;
      result     = '0;
      result.status = STATUS_CONTINUE;
      mode_eff   = cur_state.mode;

      if (start) begin
         next_state.phase = 2'd0;
         mode_eff = MODE_BLANKS;
      end

      if (start && (end_of_input || (!blank && (char_code != CHAR_HASH)))) begin
         // A region must open with a blank or a comment.
         next_state.mode = MODE_IDLE;
         result.status   = STATUS_ERROR;
      end else if (mode_eff == MODE_BLANKS) begin
         next_state.mode = MODE_BLANKS;
         if (end_of_input) begin
            next_state.mode = MODE_IDLE;
            result.status   = STATUS_END;
         end else if (blank) begin
            next_state.mode = MODE_BLANKS;
         end else if (char_code == CHAR_HASH) begin
            next_state.mode = MODE_COMMENT;
            next_state.tag  = TAG_WANT_F;
         end else begin
            next_state.mode = MODE_IDLE;
            result.status   = STATUS_END;
         end
      end else if (end_of_input) begin
         next_state.mode = MODE_IDLE;
         result.status   = STATUS_END;
      end else if ((char_code == CHAR_LF) || (char_code == CHAR_CR)) begin
         next_state.mode = MODE_BLANKS;
      end else begin
         case (cur_state.tag)
            TAG_WANT_F: begin
               if (char_code == CHAR_TAG0) begin
                  next_state.tag = TAG_WANT_W;
               end
            end
            TAG_WANT_W: begin
               next_state.tag = (char_code == CHAR_TAG1) ? TAG_WANT_COLON : TAG_STOPPED;
            end
            TAG_WANT_COLON: begin
               next_state.tag = (char_code == CHAR_COLON) ? TAG_DECODING : TAG_STOPPED;
            end
            TAG_DECODING: begin
               if (!dig[6]) begin
                  next_state.tag = TAG_STOPPED;
               end else begin
                  case (cur_state.phase)
                     2'd0: begin
                        next_state.d0    = dig[5:0];
                        next_state.phase = 2'd1;
                     end
                     2'd1: begin
                        next_state.d1    = dig[5:0];
                        next_state.phase = 2'd2;
                     end
                     2'd2: begin
                        next_state.d2    = dig[5:0];
                        next_state.phase = 2'd3;
                     end
                     default: begin
                        result.byte_hi     = {cur_state.d0, cur_state.d1[5:4]};
                        result.byte_mid    = {cur_state.d1[3:0], cur_state.d2[5:2]};
                        result.byte_lo     = {cur_state.d2[1:0], dig[5:0]};
                        result.bytes_ready = 1'b1;
                        next_state.phase   = 2'd0;
                     end
                  endcase
               end
            end
            default: begin
               next_state.tag = cur_state.tag;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/radix64_comment_payload_decoder_top.sv =====
// ----------------------------------------------------------------------------
// radix64_comment_payload_decoder_top
// Decodes radix-64 payload digits out of tagged comment lines, one character
// per word, and reports where the separator region ends.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Word contents
//   req_     in         req_valid/ready    char_code, first_of_region, end_of_input
//   rsp_     out        rsp_valid/ready    byte_hi, byte_mid, byte_lo,
//                                          bytes_ready, region_status
//
// Every request word yields exactly one response word; it passes through the
// input register and then the response register.
// Throughput is one word per cycle while the response side is not stalled: the
// decode state is updated in the same cycle that a word moves from the input register into the response register.
// A stalled response holds in its register while one more word waits in the
// input register; req_ready drops only when both are full.
// Reset is synchronous and active high; it empties both registers and returns
// the decoder to idle with the digit phase and held digits cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix64_comment_payload_decoder_top_assert.svh"

module radix64_comment_payload_decoder_top
   import r64cpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_first_of_region,
   input  wire logic       req_end_of_input,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_hi,
   output logic [7:0]      rsp_byte_mid,
   output logic [7:0]      rsp_byte_lo,
   output logic            rsp_bytes_ready,
   output logic [1:0]      rsp_region_status
);

   // Input register: holds one accepted word until the response side has room.
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_first_ff;
   logic           in_eoi_ff;

   // Response register.
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_result_ff;

   // Decoder state, advanced once per word.
   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_result_type step_result;

   logic           advance;
   logic           req_take;

   // A word leaves the input register when the response register is empty or
   // is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   r64cpd_step u_step (
      .cur_state       (state_ff),
      .char_code       (in_char_ff),
      .first_of_region (in_first_ff),
      .end_of_input    (in_eoi_ff),
      .next_state      (state_in),
      .result          (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_IDLE, tag: TAG_WANT_F, phase: 2'd0,
                           d0: 6'd0, d1: 6'd0, d2: 6'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_char_code;
         in_first_ff <= req_first_of_region;
         in_eoi_ff   <= req_end_of_input;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_byte_hi       = out_result_ff.byte_hi;
   assign rsp_byte_mid      = out_result_ff.byte_mid;
   assign rsp_byte_lo       = out_result_ff.byte_lo;
   assign rsp_bytes_ready   = out_result_ff.bytes_ready;
   assign rsp_region_status = out_result_ff.status;

   // Decoded bytes only come with a continuing region.
   `R64CPD_ASSERT_SAME(a_bytes_only_continue, rsp_valid && rsp_bytes_ready,
      rsp_region_status == STATUS_CONTINUE)

   // Without decoded bytes the byte fields read as zero.
   `R64CPD_ASSERT_SAME(a_bytes_zero_when_idle, rsp_valid && !rsp_bytes_ready,
      (rsp_byte_hi == 8'd0) && (rsp_byte_mid == 8'd0) && (rsp_byte_lo == 8'd0))

   // A word that leaves the input register shows up as a response next cycle.
   `R64CPD_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid)

   // Ending or failing a region always leaves the decoder idle.
   `R64CPD_ASSERT_NEXT(a_end_goes_idle,
      advance && (step_result.status != STATUS_CONTINUE),
      state_ff.mode == MODE_IDLE)

endmodule

`default_nettype wire
